// ===== src/bma_pkg.sv =====
// Package with shared types, constants and codes of the block message allocator.
`default_nettype none

package bma_pkg;

    // Store geometry.
    localparam int MAX_BLOCKS = 1024;
    localparam int ADDR_W     = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = 11;
    localparam int CNT_W      = 11;
    localparam int HDR_W      = LINK_W + CNT_W;

    // All ones marks the end of a list.
    localparam logic [LINK_W-1:0] EMPTY_LINK = '1;

    // Entry sizing: one header in front of the payload, rounded up to whole blocks.
    localparam int HEADER_BYTES = 32;
    localparam int BLOCK_MASK   = 63;
    localparam int BLOCK_SHIFT  = 6;
    localparam int BYTES_W      = 17;

    localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(MAX_BLOCKS);

    // Request codes.
    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_CORRUPT  = 2'd2;
    localparam logic [1:0] ST_BAD_REL  = 2'd3;

    typedef struct packed {
        logic        func;
        logic [15:0] payload_length;
        logic [31:0] message_id;
        logic [9:0]  release_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [9:0]       entry_offset;
        logic [CNT_W-1:0] entry_blocks;
        logic             was_reused;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       advance;
        logic       reuse;
        logic       push;
        logic       mark_free;
        logic       emit;
        logic [1:0] status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_release;
        logic cur_empty;
        logic cur_bad;
        logic hit;
        logic bump_over;
        logic bump_full;
        logic rel_bad;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/block_message_allocator.sv =====
// Top level of the block message allocator: controller, datapath and checks.
//
//  Channel   Signals                                 Transfer rule
//  request   start, busy, i_req                      beat taken when start & !busy
//  result    o_rsp_valid, o_rsp                      beat shown for one cycle, no stall
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data    write when valid & ready
//
// A release goes from idle to the release state, which registers its result.
// An allocation visits each list entry in a check state and then an evaluate
// state, because its header read goes through the registered read port of the
// header memory before the entry can be judged. The walk ends in the bump
// state when the list runs out, in the evaluate state of an entry that it
// reuses, or in the check state of a broken link, and that state registers
// the result. Reset is synchronous and active low; it empties both lists,
// clears the bump pointer and restores the region size, while the entry
// memories keep whatever they held. The receiver cannot stall results, and
// busy holds off new requests only while one is in work, so a new request may
// be taken in the very cycle its predecessor's result is on the strobe.
`default_nettype none

module block_message_allocator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire bma_pkg::t_req              i_req,
    output logic                            o_rsp_valid,
    output bma_pkg::t_rsp                   o_rsp,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [bma_pkg::CNT_W-1:0]  i_cfg_data
);

    bma_pkg::t_dp_cmd  dp_cmd;
    bma_pkg::t_dp_stat dp_stat;
    logic              ctrl_busy;

    // The controller sequences every request; the datapath holds the allocator state.
    bma_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_busy  (ctrl_busy),
        .o_cmd   (dp_cmd)
    );

    bma_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (dp_cmd),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (dp_stat),
        .o_rsp       (o_rsp),
        .o_rsp_valid (o_rsp_valid)
    );

    assign busy = ctrl_busy;

    // The region size is only taken between requests.
    assign o_cfg_ready = !ctrl_busy;

    // A result beat always follows a cycle in which a request was in work.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> $past(busy))
        else $error("result beat without a request in work");

    // An accepted request keeps the block busy in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start work");

    // Only successful allocations report reuse.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.was_reused) |-> (o_rsp.status == bma_pkg::ST_OK))
        else $error("reuse reported on a failed request");

    // A bad release reports a zero entry size.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status == bma_pkg::ST_BAD_REL))
        |-> (o_rsp.entry_blocks == '0))
        else $error("bad release with nonzero entry size");

endmodule

`default_nettype wire

// ===== src/bma_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module bma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/bma_ctrl.sv =====
// Controller state machine that sequences list walks, bump allocation and release.
`default_nettype none

module bma_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire bma_pkg::t_dp_stat i_stat,
    output logic                   o_busy,
    output bma_pkg::t_dp_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_BUMP  = 3'd3;
    localparam logic [2:0] S_REL   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.status = bma_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.in_release ? S_REL : S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.cur_empty) begin
                    n_state = S_BUMP;
                end else if (i_stat.cur_bad) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = bma_pkg::ST_CORRUPT;
                    n_state      = S_IDLE;
                end else begin
                    // The header read of the current entry is under way.
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.hit) begin
                    o_cmd.reuse = 1'b1;
                    o_cmd.emit  = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_BUMP: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
                if (i_stat.bump_over) begin
                    o_cmd.status = bma_pkg::ST_CORRUPT;
                end else if (i_stat.bump_full) begin
                    o_cmd.status = bma_pkg::ST_NO_SPACE;
                end else begin
                    o_cmd.push = 1'b1;
                end
            end
            S_REL: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
                if (i_stat.rel_bad) begin
                    o_cmd.status = bma_pkg::ST_BAD_REL;
                end else begin
                    o_cmd.mark_free = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== src/bma_datapath.sv =====
// Datapath with the entry stores, list heads, bump pointer and result register.
`default_nettype none

module bma_datapath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bma_pkg::t_req              i_req,
    input  wire bma_pkg::t_dp_cmd           i_cmd,
    input  wire logic                       i_cfg_we,
    input  wire logic [bma_pkg::CNT_W-1:0]  i_cfg_data,
    output bma_pkg::t_dp_stat               o_stat,
    output bma_pkg::t_rsp                   o_rsp,
    output logic                            o_rsp_valid
);

    localparam int AW = bma_pkg::ADDR_W;
    localparam int LW = bma_pkg::LINK_W;
    localparam int CW = bma_pkg::CNT_W;
    localparam int BW = bma_pkg::BYTES_W;

    bma_pkg::t_req r_req;
    logic [CW-1:0] r_blocks;
    logic [LW-1:0] r_cur;
    logic [AW-1:0] r_bound;
    logic          r_first;
    logic [LW-1:0] r_small_head;
    logic [LW-1:0] r_large_head;
    logic [CW-1:0] r_bump;
    logic [CW-1:0] r_total;
    bma_pkg::t_rsp r_rsp;
    logic          r_rsp_valid;
    bma_pkg::t_rsp n_rsp;

    logic [BW-1:0] in_bytes;
    logic [CW-1:0] in_blocks;
    logic          in_small;
    logic [CW-1:0] eff_size;
    logic [LW-1:0] head;
    logic [CW:0]   bump_end;

    logic [bma_pkg::HDR_W-1:0] hdr_rdata;
    logic [bma_pkg::HDR_W-1:0] hdr_wdata;
    logic [LW-1:0]             rd_link;
    logic [CW-1:0]             rd_size;
    logic                      free_rdata;
    logic                      free_we;
    logic [AW-1:0]             free_waddr;
    logic                      free_wdata;
    logic                      id_we;
    logic [AW-1:0]             id_waddr;

    // Entry size of the incoming request, needed at once to pick the list head.
    assign in_bytes  = BW'(i_req.payload_length) + BW'(bma_pkg::HEADER_BYTES)
                       + BW'(bma_pkg::BLOCK_MASK);
    assign in_blocks = CW'(in_bytes >> bma_pkg::BLOCK_SHIFT);
    assign in_small  = (in_blocks == CW'(1));

    assign eff_size = (r_total > CW'(bma_pkg::MAX_BLOCKS)) ? CW'(bma_pkg::MAX_BLOCKS) : r_total;
    assign head     = (r_blocks == CW'(1)) ? r_small_head : r_large_head;
    assign bump_end = (CW+1)'(r_bump) + (CW+1)'(r_blocks);

    assign rd_link = hdr_rdata[bma_pkg::HDR_W-1:CW];
    assign rd_size = hdr_rdata[CW-1:0];

    always_comb begin
        o_stat.in_release = (i_req.func == bma_pkg::FUNC_RELEASE);
        o_stat.cur_empty  = (r_cur == bma_pkg::EMPTY_LINK);
        o_stat.cur_bad    = (r_cur >= eff_size) || (!r_first && (r_cur >= LW'(r_bound)));
        o_stat.hit        = free_rdata && (rd_size == r_blocks);
        o_stat.bump_over  = (r_bump > eff_size);
        o_stat.bump_full  = (bump_end > (CW+1)'(eff_size));
        o_stat.rel_bad    = (CW'(r_req.release_offset) >= r_bump)
                            || (CW'(r_req.release_offset) >= eff_size);
    end

    // Store write ports.
    assign hdr_wdata = {head, r_blocks};

    always_comb begin
        free_we    = i_cmd.reuse || i_cmd.push || i_cmd.mark_free;
        free_wdata = i_cmd.mark_free;
        if (i_cmd.mark_free) begin
            free_waddr = r_req.release_offset;
        end else if (i_cmd.push) begin
            free_waddr = r_bump[AW-1:0];
        end else begin
            free_waddr = r_cur[AW-1:0];
        end
        id_we    = i_cmd.reuse || i_cmd.push;
        id_waddr = i_cmd.push ? r_bump[AW-1:0] : r_cur[AW-1:0];
    end

    bma_ram #(.WIDTH(bma_pkg::HDR_W), .DEPTH(bma_pkg::MAX_BLOCKS)) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_bump[AW-1:0]),
        .i_wdata (hdr_wdata),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (hdr_rdata)
    );

    bma_ram #(.WIDTH(1), .DEPTH(bma_pkg::MAX_BLOCKS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (free_waddr),
        .i_wdata (free_wdata),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (free_rdata)
    );

    // Message ids are kept with each entry but never read back by this block.
    bma_ram #(.WIDTH(32), .DEPTH(bma_pkg::MAX_BLOCKS)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (id_waddr),
        .i_wdata (r_req.message_id),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata ()
    );

    always_comb begin
        if (r_req.func == bma_pkg::FUNC_RELEASE) begin
            n_rsp.status       = i_cmd.status;
            n_rsp.entry_offset = r_req.release_offset;
            n_rsp.entry_blocks = '0;
            n_rsp.was_reused   = 1'b0;
        end else if (i_cmd.reuse) begin
            n_rsp.status       = bma_pkg::ST_OK;
            n_rsp.entry_offset = r_cur[AW-1:0];
            n_rsp.entry_blocks = r_blocks;
            n_rsp.was_reused   = 1'b1;
        end else if (i_cmd.push) begin
            n_rsp.status       = bma_pkg::ST_OK;
            n_rsp.entry_offset = r_bump[AW-1:0];
            n_rsp.entry_blocks = r_blocks;
            n_rsp.was_reused   = 1'b0;
        end else begin
            n_rsp.status       = i_cmd.status;
            n_rsp.entry_offset = '0;
            n_rsp.entry_blocks = r_blocks;
            n_rsp.was_reused   = 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req;
            r_blocks <= in_blocks;
        end
        if (i_cmd.emit) begin
            r_rsp <= n_rsp;
        end
    end

    // Walk position, list heads, bump pointer, region size and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur        <= bma_pkg::EMPTY_LINK;
            r_bound      <= '0;
            r_first      <= 1'b1;
            r_small_head <= bma_pkg::EMPTY_LINK;
            r_large_head <= bma_pkg::EMPTY_LINK;
            r_bump       <= '0;
            r_total      <= bma_pkg::TOTAL_RESET;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_rsp_valid <= i_cmd.emit;
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_cur   <= in_small ? r_small_head : r_large_head;
                r_first <= 1'b1;
            end else if (i_cmd.advance) begin
                r_bound <= r_cur[AW-1:0];
                r_first <= 1'b0;
                r_cur   <= rd_link;
            end
            if (i_cmd.push) begin
                if (r_blocks == CW'(1)) begin
                    r_small_head <= LW'(r_bump);
                end else begin
                    r_large_head <= LW'(r_bump);
                end
                r_bump <= bump_end[CW-1:0];
            end
        end
    end

    assign o_rsp       = r_rsp;
    assign o_rsp_valid = r_rsp_valid;

endmodule

`default_nettype wire

// ===== tb/sv/block_message_allocator_test.sv =====
// Self-checking testbench for the block message allocator: directed table, then random phases.
module block_message_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_LIMIT   = 100;
    // Slowest legal item: a walk over every block plus the longest sender gap, for all items.
    localparam int unsigned CYCLE_LIMIT = 2000 * (2 * bma_pkg::MAX_BLOCKS + 80) * 3;

    typedef enum logic {
        ROW_REQUEST,
        ROW_REGION
    } t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        bma_pkg::t_req             req;
        logic [bma_pkg::CNT_W-1:0] region;
        bit                        typed;
        bma_pkg::t_rsp             want;
    } t_stim_row;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    bma_pkg::t_req             i_req       = '0;
    logic                      o_rsp_valid;
    bma_pkg::t_rsp             o_rsp;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [bma_pkg::CNT_W-1:0] i_cfg_data  = '0;

    block_message_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the allocator state. Only entries reachable from a list head
    // are ever read, so the stores need no reset.
    logic [bma_pkg::LINK_W-1:0] link_of   [bma_pkg::MAX_BLOCKS];
    logic [bma_pkg::CNT_W-1:0]  blocks_of [bma_pkg::MAX_BLOCKS];
    bit                         freed     [bma_pkg::MAX_BLOCKS];
    logic [bma_pkg::LINK_W-1:0] single_head    = bma_pkg::EMPTY_LINK;
    logic [bma_pkg::LINK_W-1:0] multi_head     = bma_pkg::EMPTY_LINK;
    int unsigned                bump_at        = 0;
    logic [bma_pkg::CNT_W-1:0]  region_setting = bma_pkg::TOTAL_RESET;

    bma_pkg::t_rsp pending_responses[$];
    int            entry_starts[$];
    int            mismatch_count = 0;
    int unsigned   cycle_count    = 0;

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Works out the result beat of one request and updates the shadow state.
    function automatic bma_pkg::t_rsp expected_response(bma_pkg::t_req r);
        int unsigned                limit_blocks;
        int unsigned                byte_count;
        int unsigned                blocks;
        int unsigned                cur;
        int unsigned                bound;
        logic [bma_pkg::LINK_W-1:0] head;
        bit                         single;
        bma_pkg::t_rsp              rsp;
        limit_blocks = (region_setting > bma_pkg::MAX_BLOCKS) ? bma_pkg::MAX_BLOCKS
                                                               : region_setting;
        rsp = '0;
        if (r.func == bma_pkg::FUNC_RELEASE) begin
            rsp.entry_offset = r.release_offset;
            if (r.release_offset >= bump_at || r.release_offset >= limit_blocks) begin
                rsp.status = bma_pkg::ST_BAD_REL;
            end else begin
                freed[r.release_offset] = 1'b1;
                rsp.status = bma_pkg::ST_OK;
            end
            return rsp;
        end
        byte_count = r.payload_length + bma_pkg::HEADER_BYTES;
        blocks = (byte_count + bma_pkg::BLOCK_MASK) >> bma_pkg::BLOCK_SHIFT;
        single = (blocks == 1);
        head = single ? single_head : multi_head;
        rsp.entry_blocks = bma_pkg::CNT_W'(blocks);
        // Newest first; every link must stay inside the region and strictly descend.
        cur = head;
        bound = limit_blocks + 1;
        while (cur != bma_pkg::EMPTY_LINK) begin
            if (cur >= limit_blocks || cur >= bound) begin
                rsp.status = bma_pkg::ST_CORRUPT;
                return rsp;
            end
            if (freed[cur] && blocks_of[cur] == blocks) begin
                freed[cur] = 1'b0;
                rsp.status = bma_pkg::ST_OK;
                rsp.entry_offset = 10'(cur);
                rsp.was_reused = 1'b1;
                return rsp;
            end
            bound = cur;
            cur = link_of[cur];
        end
        if (bump_at > limit_blocks) begin
            rsp.status = bma_pkg::ST_CORRUPT;
            return rsp;
        end
        if (bump_at + blocks > limit_blocks) begin
            rsp.status = bma_pkg::ST_NO_SPACE;
            return rsp;
        end
        link_of[bump_at] = head;
        blocks_of[bump_at] = bma_pkg::CNT_W'(blocks);
        freed[bump_at] = 1'b0;
        if (single) begin
            single_head = bma_pkg::LINK_W'(bump_at);
        end else begin
            multi_head = bma_pkg::LINK_W'(bump_at);
        end
        rsp.status = bma_pkg::ST_OK;
        rsp.entry_offset = 10'(bump_at);
        bump_at = bump_at + blocks;
        return rsp;
    endfunction

    // Random request: mostly allocations from a few size classes and releases of
    // entries allocated earlier, so that freed entries get reused; the rest is noise.
    function automatic bma_pkg::t_req random_item();
        bma_pkg::t_req r;
        int unsigned   pick;
        int unsigned   blocks;
        int unsigned   lo;
        r.func = bma_pkg::FUNC_ALLOC;
        r.payload_length = 16'($urandom);
        r.message_id = $urandom;
        r.release_offset = 10'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30 && entry_starts.size() != 0) begin
            r.func = bma_pkg::FUNC_RELEASE;
            r.release_offset = 10'(entry_starts[$urandom_range(0, entry_starts.size() - 1)]);
        end else if (pick < 40) begin
            r.func = bma_pkg::FUNC_RELEASE;
            if ($urandom_range(0, 1) == 1 && bump_at != 0) begin
                r.release_offset = 10'($urandom_range(0, bump_at - 1));
            end
        end else if (pick < 95) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: blocks = 1;
                5, 6:          blocks = 2;
                7:             blocks = 3;
                8:             blocks = 4;
                default:       blocks = $urandom_range(5, 16);
            endcase
            lo = (blocks == 1) ? 0 : (blocks - 1) * (bma_pkg::BLOCK_MASK + 1)
                                     - (bma_pkg::HEADER_BYTES - 1);
            r.payload_length = 16'($urandom_range(lo, blocks * (bma_pkg::BLOCK_MASK + 1)
                                                      - bma_pkg::HEADER_BYTES));
        end else if ($urandom_range(0, 1) == 1) begin
            r.payload_length = 16'($urandom_range(0, 2047));
        end
        return r;
    endfunction

    // Presents one request beat and waits until the block takes it.
    task automatic send_item(bma_pkg::t_req r, bit typed, bma_pkg::t_rsp want);
        bma_pkg::t_rsp predicted;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        predicted = expected_response(r);
        if (r.func == bma_pkg::FUNC_ALLOC && predicted.status == bma_pkg::ST_OK
            && !predicted.was_reused) begin
            entry_starts.push_back(int'(predicted.entry_offset));
        end
        pending_responses.push_back(typed ? want : predicted);
    endtask

    task automatic hold_off(int cycles);
        if (cycles == 0) return;
        @(negedge i_clk);
        start <= 1'b0;
        i_req <= random_item();
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_region_size(logic [bma_pkg::CNT_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        region_setting = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Bursts of back-to-back beats separated by gaps; some bursts are long.
    task automatic run_random(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_item(random_item(), 1'b0, '0);
                sent++;
            end
            hold_off(($urandom_range(0, 3) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12));
        end
    endtask

    function automatic t_stim_row request_row(logic func, logic [15:0] plen, logic [31:0] id,
                                              logic [9:0] roff);
        t_stim_row row;
        row.kind = ROW_REQUEST;
        row.req = '{func, plen, id, roff};
        row.region = '0;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic t_stim_row checked_row(t_stim_row row, logic [1:0] st, logic [9:0] off,
                                              logic [bma_pkg::CNT_W-1:0] blk, logic reused);
        row.typed = 1'b1;
        row.want = '{st, off, blk, reused};
        return row;
    endfunction

    function automatic t_stim_row region_row(logic [bma_pkg::CNT_W-1:0] value);
        t_stim_row row;
        row = request_row(bma_pkg::FUNC_ALLOC, '0, '0, '0);
        row.kind = ROW_REGION;
        row.region = value;
        return row;
    endfunction

    // Each result beat is matched against the oldest outstanding expectation.
    always @(posedge i_clk) begin : check_results
        bma_pkg::t_rsp want;
        if (i_rst_n && o_rsp_valid) begin
            if (pending_responses.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected: %p", o_rsp));
            end else begin
                want = pending_responses.pop_front();
                if (o_rsp.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_rsp.status, want.status));
                if (o_rsp.entry_offset !== want.entry_offset)
                    report_mismatch($sformatf("entry_offset %0d, expected %0d",
                                              o_rsp.entry_offset, want.entry_offset));
                if (o_rsp.entry_blocks !== want.entry_blocks)
                    report_mismatch($sformatf("entry_blocks %0d, expected %0d",
                                              o_rsp.entry_blocks, want.entry_blocks));
                if (o_rsp.was_reused !== want.was_reused)
                    report_mismatch($sformatf("was_reused %0d, expected %0d",
                                              o_rsp.was_reused, want.was_reused));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_stim_row directed_rows[$];

        // Fresh region of 1024 blocks: bad releases, oversize requests, reuse
        // newest first, a release inside a multi-block entry.
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_RELEASE, 16'hFFFF,
                                32'hFFFF_FFFF, 10'd0), bma_pkg::ST_BAD_REL, 10'd0, 11'd0, 1'b0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_ALLOC, 16'hFFFF,
                                32'hFFFF_FFFF, 10'h3FF), bma_pkg::ST_NO_SPACE, 10'd0, 11'd1025,
                                1'b0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_ALLOC, 16'd0, 32'd0,
                                10'd0), bma_pkg::ST_OK, 10'd0, 11'd1, 1'b0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_ALLOC, 16'd32, 32'd1,
                                10'h155), bma_pkg::ST_OK, 10'd1, 11'd1, 1'b0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_ALLOC, 16'd33, 32'd2,
                                10'h2AA), bma_pkg::ST_OK, 10'd2, 11'd2, 1'b0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_RELEASE, 16'h0, 32'h0,
                                10'd1), bma_pkg::ST_OK, 10'd1, 11'd0, 1'b0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_ALLOC, 16'd10,
                                32'hDEAD_0001, 10'd0), bma_pkg::ST_OK, 10'd1, 11'd1, 1'b1));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_RELEASE, 16'h1234,
                                32'h5678, 10'd2), bma_pkg::ST_OK, 10'd2, 11'd0, 1'b0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_ALLOC, 16'd96,
                                32'hDEAD_0002, 10'd0), bma_pkg::ST_OK, 10'd2, 11'd2, 1'b1));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_RELEASE, 16'h0, 32'h0,
                                10'd3), bma_pkg::ST_OK, 10'd3, 11'd0, 1'b0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_ALLOC, 16'd100,
                                32'h8000_0000, 10'd0), bma_pkg::ST_OK, 10'd4, 11'd3, 1'b0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_RELEASE, 16'h0, 32'h0,
                                10'd1023), bma_pkg::ST_BAD_REL, 10'd1023, 11'd0, 1'b0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_RELEASE, 16'h0, 32'h0,
                                10'd0), bma_pkg::ST_OK, 10'd0, 11'd0, 1'b0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_RELEASE, 16'h0, 32'h0,
                                10'd1), bma_pkg::ST_OK, 10'd1, 11'd0, 1'b0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_ALLOC, 16'd5,
                                32'h0000_FFFF, 10'd0), bma_pkg::ST_OK, 10'd1, 11'd1, 1'b1));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_ALLOC, 16'd5,
                                32'hFFFF_0000, 10'd0), bma_pkg::ST_OK, 10'd0, 11'd1, 1'b1));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_ALLOC, 16'd65504, 32'h1,
                                10'd0), bma_pkg::ST_NO_SPACE, 10'd0, 11'd1024, 1'b0));
        directed_rows.push_back(request_row(bma_pkg::FUNC_ALLOC, 16'h00AA, 32'hA5A5_5A5A,
                                            10'd0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_RELEASE, 16'h0, 32'h0,
                                10'd6), bma_pkg::ST_OK, 10'd6, 11'd0, 1'b0));
        // Shrinking region: full, full with the bump pointer exactly at the end,
        // bump pointer past the end, a list head past the end, then zero size.
        directed_rows.push_back(region_row(11'd12));
        directed_rows.push_back(request_row(bma_pkg::FUNC_ALLOC, 16'd40, 32'h3, 10'd0));
        directed_rows.push_back(region_row(11'd11));
        directed_rows.push_back(request_row(bma_pkg::FUNC_ALLOC, 16'd0, 32'h4, 10'd0));
        directed_rows.push_back(region_row(11'd9));
        directed_rows.push_back(request_row(bma_pkg::FUNC_ALLOC, 16'd0, 32'h5, 10'd0));
        directed_rows.push_back(region_row(11'd5));
        directed_rows.push_back(request_row(bma_pkg::FUNC_ALLOC, 16'd200, 32'h6, 10'd0));
        directed_rows.push_back(region_row(11'd0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_RELEASE, 16'h0, 32'h0,
                                10'd0), bma_pkg::ST_BAD_REL, 10'd0, 11'd0, 1'b0));
        directed_rows.push_back(checked_row(request_row(bma_pkg::FUNC_ALLOC, 16'd0, 32'h7,
                                10'd0), bma_pkg::ST_CORRUPT, 10'd0, 11'd1, 1'b0));
        // The largest setting is clamped to the store size.
        directed_rows.push_back(region_row(11'd2047));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REGION) begin
                write_region_size(directed_rows[i].region);
            end else begin
                send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
                hold_off($urandom_range(0, 2));
            end
        end

        run_random(600);
        write_region_size(11'd0);
        run_random(40);
        write_region_size(11'd1);
        run_random(40);
        // Below the bump pointer, so most walks and fresh cuts fail.
        write_region_size(bma_pkg::CNT_W'(bump_at / 2));
        run_random(60);
        write_region_size(bma_pkg::TOTAL_RESET);
        run_random(600);
        write_region_size(11'd64);
        run_random(40);
        write_region_size(11'd1000);
        run_random(550);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== block_message_allocator.f =====
src/bma_pkg.sv
src/bma_ram.sv
src/bma_ctrl.sv
src/bma_datapath.sv
src/block_message_allocator.sv
tb/sv/block_message_allocator_test.sv
